// File: sv/bspq_pkg.sv
`default_nettype none

package bspq_pkg;

    // fixed field widths
    localparam int IDX_BITS  = 10;
    localparam int DATA_BITS = 32;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_WALK,
        ST_WR_UPD,
        ST_Q_BLK,
        ST_Q_ELEM,
        ST_Q_END,
        ST_RESULT
    } seq_state_t;

    // write strobes toward the two stores
    typedef struct packed {
        logic elem_we;
        logic blk_we;
    } mem_wr_t;

    // sequencer status
    typedef struct packed {
        logic clearing;
        logic idle;
    } seq_status_t;

endpackage

`default_nettype wire

// File: sv/bspq_store.sv
`default_nettype none

module bspq_store
    import bspq_pkg::*;
#(
    parameter int ENTRIES = 1024,
    parameter int NBLOCKS = 32,
    localparam int IDX_W  = $clog2(ENTRIES),
    localparam int BLK_W  = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1
) (
    input  wire                  aclk,
    input  mem_wr_t              mem_wr,
    input  wire [IDX_W-1:0]      elem_addr,
    input  wire [DATA_BITS-1:0]  elem_wdata,
    output logic [DATA_BITS-1:0] elem_rdata,
    input  wire [BLK_W-1:0]      blk_addr,
    input  wire [DATA_BITS-1:0]  blk_wdata,
    output logic [DATA_BITS-1:0] blk_rdata
);

    logic [DATA_BITS-1:0] elem_mem [ENTRIES];
    logic [DATA_BITS-1:0] blk_mem  [NBLOCKS];

    logic [DATA_BITS-1:0] elem_rdata_reg;
    logic [DATA_BITS-1:0] blk_rdata_reg;

    // element store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_wr.elem_we) begin
            elem_mem[elem_addr] <= elem_wdata;
        end
        elem_rdata_reg <= elem_mem[elem_addr];
    end

    // block sum store
    always_ff @(posedge aclk) begin
        if (mem_wr.blk_we) begin
            blk_mem[blk_addr] <= blk_wdata;
        end
        blk_rdata_reg <= blk_mem[blk_addr];
    end

    assign elem_rdata = elem_rdata_reg;
    assign blk_rdata  = blk_rdata_reg;

endmodule

`default_nettype wire

// File: sv/bspq_seq.sv
`default_nettype none

module bspq_seq
    import bspq_pkg::*;
#(
    parameter int ENTRIES = 1024,
    parameter int BLOCK   = 32,
    localparam int NBLOCKS = (ENTRIES + BLOCK - 1) / BLOCK,
    localparam int IDX_W   = $clog2(ENTRIES),
    localparam int BLK_W   = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1,
    localparam int CW0     = $clog2(ENTRIES + BLOCK),
    localparam int CW      = ((CW0 > IDX_BITS) ? CW0 : IDX_BITS) + 1
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire                         in_operation,
    input  wire [IDX_BITS-1:0]          in_first_index,
    input  wire [IDX_BITS-1:0]          in_last_index,
    input  wire signed [DATA_BITS-1:0]  in_new_value,
    output logic                        res_valid,
    input  wire                         res_ready,
    output logic [DATA_BITS-1:0]        res_data,
    output mem_wr_t                     mem_wr,
    output logic [IDX_W-1:0]            elem_addr,
    output logic [DATA_BITS-1:0]        elem_wdata,
    input  wire [DATA_BITS-1:0]         elem_rdata,
    output logic [BLK_W-1:0]            blk_addr,
    output logic [DATA_BITS-1:0]        blk_wdata,
    input  wire [DATA_BITS-1:0]         blk_rdata,
    output seq_status_t                 status
);

    localparam logic [CW-1:0]    ENT_C    = CW'(ENTRIES);
    localparam logic [CW-1:0]    LAST_C   = CW'(ENTRIES - 1);
    localparam logic [CW-1:0]    BLK_C    = CW'(BLOCK);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] NBLK_I   = IDX_W'(NBLOCKS);

    seq_state_t state_reg, state_next;

    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                 blk_pend_reg, blk_pend_next;
    logic                 elem_pend_reg, elem_pend_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [CW-1:0]        first_reg, first_next;
    logic [DATA_BITS-1:0] val_reg, val_next;
    logic [CW-1:0]        base_reg, base_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [DATA_BITS-1:0] acc_reg, acc_next;
    logic                 sub_reg, sub_next;
    logic                 pass2_reg, pass2_next;

    logic [CW-1:0]        first_ext;
    logic [CW-1:0]        last_ext;
    logic [CW-1:0]        first_clamp;
    logic [CW-1:0]        last_clamp;
    logic                 step_ok;
    logic [DATA_BITS-1:0] rd_word;

    assign first_ext   = CW'(in_first_index);
    assign last_ext    = CW'(in_last_index);
    assign first_clamp = (first_ext > LAST_C) ? LAST_C : first_ext;
    assign last_clamp  = (last_ext > LAST_C) ? LAST_C : last_ext;
    // another whole block fits below the target index
    assign step_ok     = (base_reg + BLK_C) <= k_reg;
    assign rd_word     = elem_pend_reg ? elem_rdata : blk_rdata;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_operation == OP_QUERY) begin
                        state_next = ST_Q_BLK;
                    end else if (first_ext < ENT_C) begin
                        state_next = ST_WR_WALK;
                    end
                end
            end
            ST_WR_WALK: begin
                if (!step_ok) begin
                    state_next = ST_WR_UPD;
                end
            end
            ST_WR_UPD: begin
                state_next = ST_IDLE;
            end
            ST_Q_BLK: begin
                if (!step_ok) begin
                    state_next = ST_Q_ELEM;
                end
            end
            ST_Q_ELEM: begin
                if (base_reg == k_reg) begin
                    state_next = ST_Q_END;
                end
            end
            ST_Q_END: begin
                if (!pass2_reg && first_reg != '0) begin
                    state_next = ST_Q_BLK;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        in_ready        = (state_reg == ST_IDLE);
        res_valid       = (state_reg == ST_RESULT);
        res_data        = acc_reg;
        status.clearing = (state_reg == ST_CLEAR);
        status.idle     = (state_reg == ST_IDLE);
        mem_wr.elem_we  = 1'b0;
        mem_wr.blk_we   = 1'b0;
        elem_addr       = k_reg[IDX_W-1:0];
        blk_addr        = blk_reg;
        elem_wdata      = val_reg;
        // read-modify-write of the block sum: add new, drop stored old
        blk_wdata       = blk_rdata + val_reg - elem_rdata;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_wr.elem_we = 1'b1;
                mem_wr.blk_we  = (clr_cnt_reg < NBLK_I);
                elem_addr      = clr_cnt_reg;
                blk_addr       = clr_cnt_reg[BLK_W-1:0];
                elem_wdata     = '0;
                blk_wdata      = '0;
            end
            ST_WR_UPD: begin
                mem_wr.elem_we = 1'b1;
                mem_wr.blk_we  = 1'b1;
            end
            ST_Q_ELEM: begin
                elem_addr = base_reg[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        clr_cnt_next   = clr_cnt_reg;
        blk_pend_next  = 1'b0;
        elem_pend_next = 1'b0;
        k_next         = k_reg;
        first_next     = first_reg;
        val_next       = val_reg;
        base_next      = base_reg;
        blk_next       = blk_reg;
        acc_next       = acc_reg;
        sub_next       = sub_reg;
        pass2_next     = pass2_reg;

        // read data lands in the cycle after its address
        if (blk_pend_reg || elem_pend_reg) begin
            acc_next = sub_reg ? (acc_reg - rd_word) : (acc_reg + rd_word);
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                if (in_valid) begin
                    k_next     = (in_operation == OP_QUERY) ? last_clamp : first_ext;
                    first_next = first_clamp;
                    val_next   = in_new_value;
                    base_next  = '0;
                    blk_next   = '0;
                    acc_next   = '0;
                    sub_next   = 1'b0;
                    pass2_next = 1'b0;
                end
            end
            ST_WR_WALK: begin
                if (step_ok) begin
                    base_next = base_reg + BLK_C;
                    blk_next  = blk_reg + 1'b1;
                end
            end
            ST_Q_BLK: begin
                if (step_ok) begin
                    blk_pend_next = 1'b1;
                    base_next     = base_reg + BLK_C;
                    blk_next      = blk_reg + 1'b1;
                end
            end
            ST_Q_ELEM: begin
                elem_pend_next = 1'b1;
                if (base_reg != k_reg) begin
                    base_next = base_reg + 1'b1;
                end
            end
            ST_Q_END: begin
                // second pass subtracts the prefix before the first index
                if (!pass2_reg && first_reg != '0) begin
                    k_next     = first_reg - 1'b1;
                    base_next  = '0;
                    blk_next   = '0;
                    sub_next   = 1'b1;
                    pass2_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            blk_pend_reg  <= 1'b0;
            elem_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            blk_pend_reg  <= blk_pend_next;
            elem_pend_reg <= elem_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg     <= k_next;
        first_reg <= first_next;
        val_reg   <= val_next;
        base_reg  <= base_next;
        blk_reg   <= blk_next;
        acc_reg   <= acc_next;
        sub_reg   <= sub_next;
        pass2_reg <= pass2_next;
    end

endmodule

`default_nettype wire

// File: sv/block_sum_point_update_range_query.sv
// Block-sum range-sum store, ENTRIES signed 32-bit elements in blocks of BLOCK.
// Input channel s_*: one word per item. s_operation selects a write of
// s_new_value into element s_first_index (no result; an index at or past
// ENTRIES is dropped) or a query of the wrapped sum over
// s_first_index..s_last_index (endpoints clamped to ENTRIES-1).
// Result channel m_*: one word per query carrying m_range_sum.
// Timing: one item at a time, s_ready is high only while the sequencer idles.
//   write: block walk, then read-modify-write.
//   query: one pass per prefix, each a walk over the block sums, then over
//   the elements, one read of the block-sum or element memory per cycle.
// Reset: synchronous, active low. After it both memories are swept to zero,
//   one element a cycle, with s_ready low.
// Stall: the result sits in an output register; the next item is taken while
//   it waits, and a later query holds in its result state until that
//   register frees.
`default_nettype none

module block_sum_point_update_range_query
    import bspq_pkg::*;
#(
    parameter int ENTRIES = 1024,
    parameter int BLOCK   = 32
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire                         s_operation,
    input  wire [IDX_BITS-1:0]          s_first_index,
    input  wire [IDX_BITS-1:0]          s_last_index,
    input  wire signed [DATA_BITS-1:0]  s_new_value,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic signed [DATA_BITS-1:0] m_range_sum
);

    localparam int NBLOCKS = (ENTRIES + BLOCK - 1) / BLOCK;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int BLK_W   = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;

    // sequencer <-> store
    mem_wr_t              mem_wr;
    logic [IDX_W-1:0]     elem_addr;
    logic [DATA_BITS-1:0] elem_wdata;
    logic [DATA_BITS-1:0] elem_rdata;
    logic [BLK_W-1:0]     blk_addr;
    logic [DATA_BITS-1:0] blk_wdata;
    logic [DATA_BITS-1:0] blk_rdata;
    seq_status_t          status;

    // sequencer -> output register
    logic                 res_valid;
    logic                 res_ready;
    logic [DATA_BITS-1:0] res_data;

    logic                 m_valid_reg, m_valid_next;
    logic [DATA_BITS-1:0] m_range_sum_reg, m_range_sum_next;

    bspq_seq #(
        .ENTRIES (ENTRIES),
        .BLOCK   (BLOCK)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .in_operation   (s_operation),
        .in_first_index (s_first_index),
        .in_last_index  (s_last_index),
        .in_new_value   (s_new_value),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_data       (res_data),
        .mem_wr         (mem_wr),
        .elem_addr      (elem_addr),
        .elem_wdata     (elem_wdata),
        .elem_rdata     (elem_rdata),
        .blk_addr       (blk_addr),
        .blk_wdata      (blk_wdata),
        .blk_rdata      (blk_rdata),
        .status         (status)
    );

    bspq_store #(
        .ENTRIES (ENTRIES),
        .NBLOCKS (NBLOCKS)
    ) u_store (
        .aclk       (aclk),
        .mem_wr     (mem_wr),
        .elem_addr  (elem_addr),
        .elem_wdata (elem_wdata),
        .elem_rdata (elem_rdata),
        .blk_addr   (blk_addr),
        .blk_wdata  (blk_wdata),
        .blk_rdata  (blk_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next     = m_valid_reg;
        m_range_sum_next = m_range_sum_reg;
        if (res_valid && res_ready) begin
            m_valid_next     = 1'b1;
            m_range_sum_next = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_range_sum_reg <= m_range_sum_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_range_sum = m_range_sum_reg;

`ifndef NO_ASSERTIONS
    // no item and no result while the stores are being swept
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_ready && !res_valid && !status.idle)
        else $error("item or result during clearing sweep");

    // a write never produces a result word
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == OP_WRITE) |=> !res_valid)
        else $error("result after write");

    // a stalled internal result holds its value
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> res_valid && $stable(res_data))
        else $error("internal result dropped or changed while stalled");
`endif

endmodule

`default_nettype wire
